@@ hdl/kdlp_pkg.sv @@
// kdlp_pkg: shared types and constants for the key debounce / long press unit
// no dependencies; imported by kdlp_front, kdlp_queue, kdlp_back and the top level
package kdlp_pkg;

	// key codes
	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_1    = 3'd1;
	localparam logic [2:0] KEY_2    = 3'd2;
	localparam logic [2:0] KEY_3    = 3'd3;
	localparam logic [2:0] KEY_4    = 3'd4;
	localparam logic [2:0] KEY_5    = 3'd5;
	localparam logic [2:0] KEY_6    = 3'd6;

	// port a line patterns after masking, active low
	localparam logic [7:0] PORT_A_MASK = 8'h1d;
	localparam logic [7:0] PAT_IDLE    = 8'h1d;
	localparam logic [7:0] PAT_KEY_1   = 8'h0d;
	localparam logic [7:0] PAT_KEY_2   = 8'h15;
	localparam logic [7:0] PAT_KEY_3   = 8'h19;
	localparam logic [7:0] PAT_KEY_4   = 8'h1c;
	localparam logic [7:0] PAT_KEY_6   = 8'h09;

	// configuration register indexes
	localparam int         CFG_IDX_W       = 2;
	localparam logic [1:0] CFG_PRESCALE    = 2'd0;
	localparam logic [1:0] CFG_SHORT       = 2'd1;
	localparam logic [1:0] CFG_MEDIUM      = 2'd2;
	localparam logic [1:0] CFG_LONG        = 2'd3;
	localparam int         CFG_DATA_W      = 8;

	// register reset values
	localparam logic [7:0] PRESCALE_RESET  = 8'd5;
	localparam logic [7:0] SHORT_RESET     = 8'd2;
	localparam logic [7:0] MEDIUM_RESET    = 8'd150;
	localparam logic [7:0] LONG_RESET      = 8'd250;

	localparam int UNIT_COUNT_WIDTH_DEF = 9;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	// classified scan item handed from front to back
	typedef struct packed {
		logic       tick;
		logic [2:0] key;
		logic       display_off;
	} kdlp_item_t;

	// result pulses
	typedef struct packed {
		logic short_press;
		logic press_medium;
		logic press_long;
		logic wake_display;
		logic key_released;
	} kdlp_flags_t;

endpackage

@@ hdl/kdlp_front.sv @@
// kdlp_front: accepts scan items and decodes the raw port lines into a key code
// depends on kdlp_pkg; feeds kdlp_queue
module kdlp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                tick,
	input  logic [7:0]          port_a_lines,
	input  logic                port_b_line,
	input  logic                display_off,
	output logic                push,
	output kdlp_pkg::kdlp_item_t push_data,
	input  logic                push_ready
);
	import kdlp_pkg::*;

	logic [2:0] decoded_key_q;
	logic [2:0] key_next;
	logic [7:0] masked;

	assign masked = port_a_lines & PORT_A_MASK;

	always_comb begin
		key_next = decoded_key_q;
		if (tick) begin
			case (masked)
				PAT_IDLE:  key_next = port_b_line ? KEY_NONE : KEY_5;
				PAT_KEY_1: key_next = KEY_1;
				PAT_KEY_2: key_next = KEY_2;
				PAT_KEY_3: key_next = KEY_3;
				PAT_KEY_4: key_next = KEY_4;
				PAT_KEY_6: key_next = KEY_6;
				// unknown pattern holds the last code
				default:   key_next = decoded_key_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoded_key_q <= KEY_NONE;
		end else if (in_valid && push_ready) begin
			decoded_key_q <= key_next;
		end
	end

	assign in_ready              = push_ready;
	assign push                  = in_valid && push_ready;
	assign push_data.tick        = tick;
	assign push_data.key         = key_next;
	assign push_data.display_off = display_off;

endmodule

@@ hdl/kdlp_queue.sv @@
// kdlp_queue: short fifo of classified items between front and back
// depends on kdlp_pkg
module kdlp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  kdlp_pkg::kdlp_item_t push_data,
	output logic                 push_ready,
	input  logic                 pop,
	output logic                 pop_valid,
	output kdlp_pkg::kdlp_item_t pop_data
);
	import kdlp_pkg::*;

	kdlp_item_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("pointers differ on empty queue");
`endif

endmodule

@@ hdl/kdlp_back.sv @@
// kdlp_back: debounce, prescaler, unit counter and hold detection with result register
// depends on kdlp_pkg; takes items from kdlp_queue, holds the configuration registers
module kdlp_back #(
	parameter int UNIT_COUNT_WIDTH = kdlp_pkg::UNIT_COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [kdlp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kdlp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                q_valid,
	input  kdlp_pkg::kdlp_item_t                q_data,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          res_key,
	output kdlp_pkg::kdlp_flags_t               res_flags
);
	import kdlp_pkg::*;

	localparam logic [UNIT_COUNT_WIDTH-1:0] UNIT_MAX = '1;

	logic [7:0] prescale_q, short_q, medium_q, long_q;

	logic [2:0]                  stable_key_q, stable_n;
	logic                        counting_q, counting_n;
	logic [7:0]                  tick_count_q, tick_n, tick_inc;
	logic [UNIT_COUNT_WIDTH-1:0] unit_count_q, unit_n;
	logic [2:0]                  reported_key_q, reported_n;
	kdlp_flags_t                 flags_n;

	logic        out_valid_q;
	logic [2:0]  res_key_q;
	kdlp_flags_t res_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= PRESCALE_RESET;
			short_q    <= SHORT_RESET;
			medium_q   <= MEDIUM_RESET;
			long_q     <= LONG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRESCALE: prescale_q <= cfg_data;
				CFG_SHORT:    short_q    <= cfg_data;
				CFG_MEDIUM:   medium_q   <= cfg_data;
				CFG_LONG:     long_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_comb begin
		stable_n   = stable_key_q;
		counting_n = counting_q;
		tick_n     = tick_count_q;
		unit_n     = unit_count_q;
		reported_n = reported_key_q;
		tick_inc   = '0;
		flags_n    = '0;
		if (q_data.tick) begin
			if (stable_key_q != q_data.key) begin
				stable_n = q_data.key;
				if (q_data.key == KEY_NONE) begin
					counting_n            = 1'b0;
					flags_n.key_released = 1'b1;
				end else begin
					counting_n = 1'b1;
					tick_n     = '0;
					unit_n     = '0;
				end
			end
			if (counting_n) begin
				tick_inc = tick_n + 8'd1;
				// a prescale of zero gives a unit on every tick
				if (tick_inc >= prescale_q) begin
					tick_n = '0;
					if (unit_n != UNIT_MAX) begin
						unit_n = unit_n + 1'b1;
					end
					// first matching threshold wins
					if (unit_n == UNIT_COUNT_WIDTH'(short_q)) begin
						reported_n = stable_n;
						if (q_data.display_off && stable_n != KEY_NONE) begin
							flags_n.wake_display = 1'b1;
						end else begin
							flags_n.short_press = 1'b1;
						end
					end else if ((stable_n inside {KEY_2, KEY_5, KEY_6})
							&& unit_n == UNIT_COUNT_WIDTH'(medium_q)) begin
						reported_n           = stable_n;
						flags_n.press_medium = 1'b1;
					end else if (stable_n == KEY_4 && unit_n == UNIT_COUNT_WIDTH'(long_q)) begin
						counting_n         = 1'b0;
						reported_n         = stable_n;
						flags_n.press_long = 1'b1;
					end
				end else begin
					tick_n = tick_inc;
				end
			end
		end
	end

	// take the next item when the result register is empty or being drained
	assign q_pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_key_q   <= KEY_NONE;
			counting_q     <= 1'b0;
			tick_count_q   <= '0;
			unit_count_q   <= '0;
			reported_key_q <= KEY_NONE;
			out_valid_q    <= 1'b0;
		end else begin
			if (q_pop) begin
				stable_key_q   <= stable_n;
				counting_q     <= counting_n;
				tick_count_q   <= tick_n;
				unit_count_q   <= unit_n;
				reported_key_q <= reported_n;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_key_q   <= reported_n;
			res_flags_q <= flags_n;
		end
	end

	assign out_valid = out_valid_q;
	assign res_key   = res_key_q;
	assign res_flags = res_flags_q;

endmodule

@@ hdl/key_debounce_long_press_unit.sv @@
// key_debounce_long_press_unit: key scanner with debounce and hold-time detection
// depends on kdlp_pkg, kdlp_front, kdlp_queue, kdlp_back
//
// input channel (in_valid/in_ready): one scan item per transfer; tick=1 is a 4 ms
//   scan tick with the raw port lines, tick=0 changes nothing but still gives a result
// output channel (out_valid/out_ready): exactly one result per input item, in order:
//   the last reported key code and one-item pulses for short press, 3 s hold,
//   5 s hold, display wake and key release
// cfg_we/cfg_index/cfg_data: write prescale_ticks, short_units, medium_units,
//   long_units (index 0..3) while the block is idle
// the input transfer writes the item into the queue, and the back loads the result
//   register from the queue entry when the result register is free or draining
// throughput: one item per cycle while out_ready is high; the front decodes into
//   a 2-entry queue, and the back updates the counters and result register at once
// a stalled receiver holds the result register; the queue fills and in_ready
//   drops once the queue holds two items
// reset clears the key state, counters, queue and registers to their defaults
module key_debounce_long_press_unit #(
	parameter int UNIT_COUNT_WIDTH = kdlp_pkg::UNIT_COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            tick,
	input  logic [7:0]                      port_a_lines,
	input  logic                            port_b_line,
	input  logic                            display_off,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      key_code,
	output logic                            short_press,
	output logic                            press_medium,
	output logic                            press_long,
	output logic                            wake_display,
	output logic                            key_released,
	input  logic                            cfg_we,
	input  logic [kdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kdlp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kdlp_pkg::*;

	logic        push, push_ready, pop, pop_valid;
	kdlp_item_t  push_data, pop_data;
	kdlp_flags_t flags;

	kdlp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.tick         (tick),
		.port_a_lines (port_a_lines),
		.port_b_line  (port_b_line),
		.display_off  (display_off),
		.push         (push),
		.push_data    (push_data),
		.push_ready   (push_ready)
	);

	kdlp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data)
	);

	kdlp_back #(
		.UNIT_COUNT_WIDTH (UNIT_COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (pop_valid),
		.q_data    (pop_data),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_key   (key_code),
		.res_flags (flags)
	);

	assign short_press  = flags.short_press;
	assign press_medium = flags.press_medium;
	assign press_long   = flags.press_long;
	assign wake_display = flags.wake_display;
	assign key_released = flags.key_released;

endmodule
